>>> rtl/gstc_pkg.sv
// ----------------------------------------------------------------------------
// gstc_pkg: shared types and constants for the turn controller
// Register indexes, gain tables, band limits and the settle-timer control.
// ----------------------------------------------------------------------------
package gstc_pkg;

  localparam int unsigned ErrW   = 18;  // target - (heading - origin)
  localparam int unsigned MagW   = 17;  // |error|
  localparam int unsigned GainW  = 9;   // Q8.8, up to 1.0
  localparam int unsigned OpAW   = 20;  // shared multiplier operand A
  localparam int unsigned ProdW  = OpAW + GainW;
  localparam int unsigned LimW   = 14;  // max_speed * 100 <= 12700

  // configuration register indexes
  localparam logic [1:0] CfgTargetTurn = 2'd0;
  localparam logic [1:0] CfgMaxSpeed   = 2'd1;
  localparam logic [1:0] CfgFastMode   = 2'd2;

  // Q8.8 gains
  localparam logic [GainW-1:0] G014 = 9'd36;
  localparam logic [GainW-1:0] G030 = 9'd77;
  localparam logic [GainW-1:0] G040 = 9'd102;
  localparam logic [GainW-1:0] G060 = 9'd154;
  localparam logic [GainW-1:0] G070 = 9'd179;
  localparam logic [GainW-1:0] G080 = 9'd205;
  localparam logic [GainW-1:0] G100 = 9'd256;

  // band edges and speed offsets, centidegrees / centipercent
  localparam logic [15:0]     BandSmall = 16'd6000;
  localparam logic [15:0]     BandMid   = 16'd11000;
  localparam logic [MagW-1:0] ErrHigh   = 17'd5000;
  localparam logic [MagW-1:0] ErrMid    = 17'd3000;
  localparam logic [MagW-1:0] ErrNear   = 17'd100;
  localparam logic [MagW-1:0] OffHigh   = 17'd4500;
  localparam logic [MagW-1:0] OffMid    = 17'd1600;
  localparam logic [OpAW-1:0] KiBias    = 20'd51200;  // 200 in Q8.8
  localparam logic [7:0]      SettleMs  = 8'd50;

  typedef struct packed {
    logic [GainW-1:0] kp;
    logic [GainW-1:0] ki;
  } gstc_gain_t;

  typedef struct packed {
    logic upd;    // tick is being retired
    logic start;  // start beat
    logic near;   // |error| under one degree
  } gstc_settle_ctrl_t;

  function automatic gstc_gain_t gain_sel(input logic [15:0] abs_t, input logic fast);
    gstc_gain_t g;
    if (abs_t < BandSmall) begin
      g.kp = fast ? G070 : G060;
      g.ki = fast ? G060 : G030;
    end else if (abs_t < BandMid) begin
      g.kp = fast ? G070 : G014;
      g.ki = fast ? G040 : G100;
    end else begin
      g.kp = fast ? G080 : G070;
      g.ki = fast ? G080 : G060;
    end
    return g;
  endfunction

endpackage

>>> rtl/gstc_mul.sv
// ----------------------------------------------------------------------------
// gstc_mul: shared multiplier
// One unsigned multiply per issue, product registered for the next step.
// ----------------------------------------------------------------------------
module gstc_mul (
  input  logic                           clk_i,
  input  logic                           issue_i,
  input  logic [gstc_pkg::OpAW-1:0]      a_i,
  input  logic [gstc_pkg::GainW-1:0]     b_i,
  output logic [gstc_pkg::ProdW-1:0]     prod_o
);

  logic [gstc_pkg::ProdW-1:0] prod_q, prod_d;

  always_comb begin
    prod_d = prod_q;
    if (issue_i) begin
      prod_d = gstc_pkg::ProdW'(a_i) * gstc_pkg::ProdW'(b_i);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

>>> rtl/gstc_settle.sv
// ----------------------------------------------------------------------------
// gstc_settle: settle timer and settled flag
// Accumulates elapsed ms while the error is small; freezes once settled.
// ----------------------------------------------------------------------------
module gstc_settle (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  gstc_pkg::gstc_settle_ctrl_t ctrl_i,
  input  logic [7:0]                  elapsed_i,
  output logic                        was_done_o,
  output logic                        done_next_o
);

  logic [7:0] settle_q, settle_d;
  logic       done_q, done_d;
  logic [7:0] base_settle;
  logic       base_done;
  logic [7:0] el;
  logic [8:0] sum;

  always_comb begin
    base_settle = ctrl_i.start ? 8'd0 : settle_q;
    base_done   = ctrl_i.start ? 1'b0 : done_q;
    el          = ctrl_i.start ? 8'd0 : elapsed_i;
    sum         = {1'b0, base_settle} + {1'b0, el};
    settle_d    = base_settle;
    done_d      = base_done;
    if (!base_done) begin
      if (ctrl_i.near) begin
        settle_d = sum[8] ? 8'hFF : sum[7:0];
        done_d   = settle_d > gstc_pkg::SettleMs;
      end else begin
        settle_d = 8'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= 8'd0;
      done_q   <= 1'b0;
    end else if (ctrl_i.upd) begin
      settle_q <= settle_d;
      done_q   <= done_d;
    end
  end

  assign was_done_o  = base_done;
  assign done_next_o = done_d;

  // settled only clears on a start beat
  a_done_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(done_q) |-> $past(ctrl_i.upd && ctrl_i.start))
    else $error("settled flag cleared without start");

  // once settled, the timer holds until the next start
  a_timer_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.upd && done_q && !ctrl_i.start) |=> $stable(settle_q))
    else $error("settle timer moved after settling");

endmodule

>>> rtl/gain_scheduled_turn_controller_unit.sv
// ----------------------------------------------------------------------------
// gain_scheduled_turn_controller_unit: gain-scheduled turn-in-place regulator
// One tick in (heading, elapsed ms, start), one result out (drive speed,
// remaining error, settled). Registers target_turn, max_speed, fast_mode.
//
// Usage:
//  - Input channel in_valid_i/in_stall_o; a beat moves when valid and not
//    stall. Output channel out_valid_o/out_stall_i, same rule.
//  - Config: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 target,
//    1 max speed, 2 fast mode). Write only while idle.
//  - Each tick runs these steps from accept to result: err calc together with
//    the speed limit multiply, KP multiply, KI multiply, then clamp and
//    retire. All three products go through one shared multiplier, so a new
//    tick is accepted only once the last has retired and returned to idle;
//    in_stall_o is high while a tick is in flight.
//  - The result sits in an output register; a new tick is accepted while it
//    waits, but that tick cannot retire until the result is taken.
//  - Reset clears origin, settle timer and settled flag; target 0, max 100,
//    fast mode off. A stalled result holds its values.
// ----------------------------------------------------------------------------
module gain_scheduled_turn_controller_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               start_new_i,
  input  logic [15:0]        heading_i,
  input  logic [7:0]         elapsed_ms_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [14:0] drive_speed_o,
  output logic signed [16:0] remaining_error_o,
  output logic               settled_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ERR  = 5'b00010,
    S_KP   = 5'b00100,
    S_KI   = 5'b01000,
    S_FIN  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // config
  logic signed [15:0] target_q;
  logic [6:0]         max_speed_q;
  logic               fast_q;

  // tick state
  logic [15:0] origin_q;
  logic [15:0] heading_q;
  logic [7:0]  elapsed_q;
  logic        start_q;

  // datapath
  logic signed [gstc_pkg::ErrW-1:0] err_q, err_d;
  logic [gstc_pkg::MagW-1:0]        e_q, e_d;
  logic [gstc_pkg::LimW-1:0]        lim_q;
  logic [gstc_pkg::MagW-1:0]        hi_q, hi_d;
  logic                             big_q;

  logic                             in_acc, out_free, retire;
  logic [15:0]                      abs_t;
  gstc_pkg::gstc_gain_t             gain;
  logic                             mul_issue;
  logic [gstc_pkg::OpAW-1:0]        mul_a;
  logic [gstc_pkg::GainW-1:0]       mul_b;
  logic [gstc_pkg::ProdW-1:0]       prod;
  logic [24:0]                      hi_sum;
  logic [27:0]                      lo_sum;
  logic [gstc_pkg::MagW-1:0]        mag_raw;
  logic [gstc_pkg::LimW-1:0]        mag;
  logic [14:0]                      speed;
  logic [16:0]                      rep;
  logic                             was_done, done_next;
  gstc_pkg::gstc_settle_ctrl_t      sctrl;

  logic               out_valid_q;
  logic [14:0]        drive_q;
  logic [16:0]        rem_q;
  logic               settled_q;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign retire   = (state_q == S_FIN) && out_free;
  assign in_stall_o = (state_q != S_IDLE);

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= 16'sd0;
      max_speed_q <= 7'd100;
      fast_q      <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gstc_pkg::CfgTargetTurn: target_q    <= cfg_data_i;
        gstc_pkg::CfgMaxSpeed:   max_speed_q <= cfg_data_i[6:0];
        gstc_pkg::CfgFastMode:   fast_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_acc) state_d = S_ERR;
      S_ERR:   state_d = S_KP;
      S_KP:    state_d = S_KI;
      S_KI:    state_d = S_FIN;
      S_FIN:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      origin_q <= 16'd0;
    end else begin
      state_q <= state_d;
      if (in_acc && start_new_i) begin
        origin_q <= heading_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      heading_q <= heading_i;
      elapsed_q <= elapsed_ms_i;
      start_q   <= start_new_i;
    end
  end

  // error: origin already updated for a start beat
  always_comb begin
    err_d = gstc_pkg::ErrW'(target_q)
          - (gstc_pkg::ErrW'({1'b0, heading_q}) - gstc_pkg::ErrW'({1'b0, origin_q}));
    e_d   = err_d[gstc_pkg::ErrW-1] ? gstc_pkg::MagW'(-err_d) : gstc_pkg::MagW'(err_d);
  end

  assign abs_t = target_q[15] ? 16'(-target_q) : 16'(target_q);
  assign gain  = gstc_pkg::gain_sel(abs_t, fast_q);

  // shared multiplier operand select
  always_comb begin
    mul_issue = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state_q)
      S_ERR: begin
        mul_issue = 1'b1;
        mul_a     = gstc_pkg::OpAW'(max_speed_q);
        mul_b     = 9'd100;
      end
      S_KP: begin
        mul_issue = 1'b1;
        mul_a     = gstc_pkg::OpAW'(e_q);
        mul_b     = gain.kp;
      end
      S_KI: begin
        // only meaningful when |err| <= 3000, where e*kp fits 20 bits
        mul_issue = 1'b1;
        mul_a     = prod[gstc_pkg::OpAW-1:0] + gstc_pkg::KiBias;
        mul_b     = gain.ki;
      end
      default: ;
    endcase
  end

  gstc_mul u_mul (
    .clk_i   (clk_i),
    .issue_i (mul_issue),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .prod_o  (prod)
  );

  always_comb begin
    hi_sum = prod[24:0] + 25'd128;
    hi_d   = gstc_pkg::MagW'(hi_sum[24:8])
           + ((e_q > gstc_pkg::ErrHigh) ? gstc_pkg::OffHigh : gstc_pkg::OffMid);
    lo_sum = prod[27:0] + 28'd32768;
    mag_raw = big_q ? hi_q : gstc_pkg::MagW'(lo_sum[27:16]);
    mag     = (mag_raw < gstc_pkg::MagW'(lim_q)) ? mag_raw[gstc_pkg::LimW-1:0] : lim_q;
    speed   = err_q[gstc_pkg::ErrW-1] ? 15'(-{1'b0, mag}) : {1'b0, mag};
    case (err_q[gstc_pkg::ErrW-1:gstc_pkg::ErrW-2])
      2'b01:   rep = 17'h0FFFF;
      2'b10:   rep = 17'h10000;
      default: rep = err_q[16:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_ERR: begin
        err_q <= err_d;
        e_q   <= e_d;
      end
      S_KP: begin
        lim_q <= prod[gstc_pkg::LimW-1:0];
        big_q <= e_q > gstc_pkg::ErrMid;
      end
      S_KI: hi_q <= hi_d;
      default: ;
    endcase
  end

  assign sctrl.upd   = retire;
  assign sctrl.start = start_q;
  assign sctrl.near  = e_q < gstc_pkg::ErrNear;

  gstc_settle u_settle (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (sctrl),
    .elapsed_i   (elapsed_q),
    .was_done_o  (was_done),
    .done_next_o (done_next)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (retire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (retire) begin
      drive_q   <= was_done ? 15'd0 : speed;
      rem_q     <= rep;
      settled_q <= done_next;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign drive_speed_o     = drive_q;
  assign remaining_error_o = rem_q;
  assign settled_o         = settled_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_ERR))
    else $error("tick accepted but sequencer did not start");

  a_speed_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (drive_speed_o <= $signed({1'b0, lim_q}))
                 && (drive_speed_o >= -$signed({1'b0, lim_q})))
    else $error("drive speed beyond limit");

  a_speed_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && remaining_error_o < 0) |-> (drive_speed_o <= 0))
    else $error("drive speed sign disagrees with error");

endmodule
